// ----- hw/rtl/ecpwm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ecpwm_pkg
// Shared types and constants for the encoder controlled pwm core: payload
// structs, field widths, register indexes and detent phase codes.
// ----------------------------------------------------------------------------
package ecpwm_pkg;

   // field widths
   localparam int WIDTH_W  = 16;  // pulse width and period
   localparam int FACTOR_W = 8;   // step factor
   localparam int PHASE_W  = 3;   // detent phase, two's complement

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_PERIOD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_FACTOR = 2'd1;

   // register reset values
   localparam logic [WIDTH_W-1:0]  PWM_PERIOD_RESET  = 16'd1000;
   localparam logic [FACTOR_W-1:0] STEP_FACTOR_RESET = 8'd2;

   // default tick counter width
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // detent phase codes
   localparam logic signed [PHASE_W-1:0] PHASE_IDLE = 3'sd0;
   localparam logic signed [PHASE_W-1:0] PHASE_POS1 = 3'sd1;
   localparam logic signed [PHASE_W-1:0] PHASE_POS2 = 3'sd2;
   localparam logic signed [PHASE_W-1:0] PHASE_HOLD = 3'sd3;
   localparam logic signed [PHASE_W-1:0] PHASE_NEG1 = -3'sd1;
   localparam logic signed [PHASE_W-1:0] PHASE_NEG2 = -3'sd2;

   // input transaction
   typedef struct packed {
      logic enc_a;
      logic enc_b;
   } req_payload_type;

   // result transaction
   typedef struct packed {
      logic               pwm_out;
      logic               led_shorter;
      logic               led_longer;
      logic [WIDTH_W-1:0] width_now;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ecpwm_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ecpwm_divider
// Restoring divider, one quotient bit per cycle: 16-bit dividend over an
// 8-bit nonzero divisor. Pulses done in the cycle after the last step.
// ----------------------------------------------------------------------------
module ecpwm_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [ecpwm_pkg::WIDTH_W-1:0]     dividend,
   input  wire logic [ecpwm_pkg::FACTOR_W-1:0]    divisor,
   output logic                                   done,
   output logic      [ecpwm_pkg::WIDTH_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(ecpwm_pkg::WIDTH_W + 1);

   logic [ecpwm_pkg::WIDTH_W-1:0]  quo_ff, quo_in;
   logic [ecpwm_pkg::FACTOR_W-1:0] rem_ff, rem_in;
   logic [ecpwm_pkg::FACTOR_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [ecpwm_pkg::FACTOR_W:0]   trial;
   logic [ecpwm_pkg::FACTOR_W:0]   diff;
   logic                           fits;

   // one trial subtraction per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[ecpwm_pkg::WIDTH_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});
   end

   // step sequencing
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(ecpwm_pkg::WIDTH_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ecpwm_pkg::WIDTH_W-2:0], fits};
         rem_in = fits ? diff[ecpwm_pkg::FACTOR_W-1:0] : trial[ecpwm_pkg::FACTOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/encoder_controlled_pwm_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_controlled_pwm_core
// PWM generator whose pulse width is stepped by a quadrature encoder: one
// input transaction per sample tick, one result transaction per tick.
//
//   channel | direction | ports                              | content
//   req     | in        | req_valid, req_stall, req_data     | encoder levels a, b
//   rsp     | out       | rsp_valid, rsp_stall, rsp_data     | pwm level, leds, width
//   csr     | in        | csr_wr_en, csr_index, csr_wdata    | period, step factor
//
// A tick without a width change, or a lengthen from zero width, goes from
// accept through the deliver state to the output register; a detent that
// divides (shorten, or the period bound of a lengthen) also passes the
// divide state and the bit-serial divider (16 steps). One transaction is in
// flight at a time; a finished result waits in the output register while
// the next one is accepted. Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module encoder_controlled_pwm_core #(
   parameter int COUNT_WIDTH = ecpwm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire ecpwm_pkg::req_payload_type            req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output ecpwm_pkg::rsp_payload_type                 rsp_data,
   input  wire logic                                  csr_wr_en,
   input  wire logic [ecpwm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ecpwm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int WW    = ecpwm_pkg::WIDTH_W;
   localparam int FW    = ecpwm_pkg::FACTOR_W;
   localparam int CMP_W = (COUNT_WIDTH > WW) ? COUNT_WIDTH : WW;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_DIVIDE  = 3'b010,
      ST_DELIVER = 3'b100
   } state_type;

   state_type                       state_ff, state_in;
   logic [WW-1:0]                   period_ff, period_in;
   logic [FW-1:0]                   factor_ff, factor_in;
   logic [COUNT_WIDTH-1:0]          counter_ff, counter_in;
   logic [WW-1:0]                   width_ff, width_in;
   logic signed [ecpwm_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                            level_ff, level_in;
   logic                            shorter_ff, shorter_in;
   logic                            longer_ff, longer_in;
   logic                            lengthen_ff, lengthen_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ecpwm_pkg::rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                            req_accept;
   logic [FW-1:0]                   eff_factor;
   logic [WW-1:0]                   width_clamp;
   logic [CMP_W-1:0]                counter_ext, width_ext, period_ext;
   logic                            tick_clear;
   logic                            level_next;
   logic signed [ecpwm_pkg::PHASE_W-1:0] phase_next;
   logic                            detent_cw;
   logic                            detent_ccw;
   logic                            div_start;
   logic [WW-1:0]                   div_dividend;
   logic                            div_done;
   logic [WW-1:0]                   div_quotient;
   logic [WW+FW-1:0]                product;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign eff_factor = (factor_ff == '0) ? FW'(1) : factor_ff;

   // width clamp and pwm compare
   always_comb begin
      width_clamp = (width_ff > period_ff) ? period_ff : width_ff;
      counter_ext = CMP_W'(counter_ff);
      width_ext   = CMP_W'(width_clamp);
      period_ext  = CMP_W'(period_ff);
      tick_clear  = 1'b0;
      level_next  = level_ff;
      if (counter_ext < width_ext) begin
         level_next = 1'b1;
      end else if (counter_ext < period_ext) begin
         level_next = 1'b0;
      end else begin
         tick_clear = 1'b1;
      end
   end

   // detent tracker
   always_comb begin
      phase_next = phase_ff;
      detent_cw  = 1'b0;
      detent_ccw = 1'b0;
      unique case ({req_data.enc_a, req_data.enc_b})
         2'b11: phase_next = ecpwm_pkg::PHASE_IDLE;
         2'b10: begin
            if (phase_ff == ecpwm_pkg::PHASE_POS2) begin
               detent_cw  = 1'b1;
               phase_next = ecpwm_pkg::PHASE_HOLD;
            end else if (phase_ff == ecpwm_pkg::PHASE_IDLE) begin
               phase_next = ecpwm_pkg::PHASE_NEG1;
            end
         end
         2'b01: begin
            if (phase_ff == ecpwm_pkg::PHASE_NEG2) begin
               detent_ccw = 1'b1;
               phase_next = ecpwm_pkg::PHASE_HOLD;
            end else if (phase_ff == ecpwm_pkg::PHASE_IDLE) begin
               phase_next = ecpwm_pkg::PHASE_POS1;
            end
         end
         default: begin
            if (phase_ff == ecpwm_pkg::PHASE_POS1) begin
               phase_next = ecpwm_pkg::PHASE_POS2;
            end else if (phase_ff == ecpwm_pkg::PHASE_NEG1) begin
               phase_next = ecpwm_pkg::PHASE_NEG2;
            end
         end
      endcase
   end

   // shorten divides the width, lengthen bounds against period over factor
   assign div_dividend = detent_cw ? width_clamp : period_ff;
   assign product      = (WW+FW)'(width_ff) * (WW+FW)'(eff_factor);

   ecpwm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (eff_factor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      width_in     = width_ff;
      phase_in     = phase_ff;
      level_in     = level_ff;
      shorter_in   = shorter_ff;
      longer_in    = longer_ff;
      lengthen_in  = lengthen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               counter_in  = tick_clear ? '0 : counter_ff + COUNT_WIDTH'(1);
               level_in    = level_next;
               phase_in    = phase_next;
               width_in    = width_clamp;
               lengthen_in = detent_ccw;
               state_in    = ST_DELIVER;
               if (detent_cw) begin
                  shorter_in = 1'b1;
                  longer_in  = 1'b0;
                  div_start  = 1'b1;
                  state_in   = ST_DIVIDE;
               end
               if (detent_ccw) begin
                  shorter_in = 1'b0;
                  longer_in  = 1'b1;
                  if (width_clamp == '0) begin
                     width_in = WW'(1);
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIVIDE;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (!lengthen_ff) begin
                  width_in = div_quotient;
               end else if (width_ff <= div_quotient) begin
                  width_in = product[WW-1:0];
               end
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.pwm_out     = level_ff;
               rsp_data_in.led_shorter = shorter_ff;
               rsp_data_in.led_longer  = longer_ff;
               rsp_data_in.width_now   = width_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // configuration writes
   always_comb begin
      period_in = period_ff;
      factor_in = factor_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ecpwm_pkg::CSR_PWM_PERIOD:  period_in = csr_wdata[WW-1:0];
            ecpwm_pkg::CSR_STEP_FACTOR: factor_in = csr_wdata[FW-1:0];
            default: ;
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= ecpwm_pkg::PWM_PERIOD_RESET;
         factor_ff    <= ecpwm_pkg::STEP_FACTOR_RESET;
         counter_ff   <= '0;
         width_ff     <= '0;
         phase_ff     <= ecpwm_pkg::PHASE_IDLE;
         level_ff     <= 1'b0;
         shorter_ff   <= 1'b0;
         longer_ff    <= 1'b0;
         lengthen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         factor_ff    <= factor_in;
         counter_ff   <= counter_in;
         width_ff     <= width_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         shorter_ff   <= shorter_in;
         longer_ff    <= longer_in;
         lengthen_ff  <= lengthen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
